// File: rtl/lse_pkg.sv
// lse_pkg: shared types and defaults for the LIFO stack engine.
// No dependencies; used by lse_in_if, lse_out_if, lse_cell and lifo_stack_engine.
package lse_pkg;

    localparam int DEFAULT_STACK_DEPTH = 64;
    localparam int DEFAULT_VALUE_WIDTH = 32;
    localparam int MODE_W              = 2;
    localparam int STATUS_W            = 2;
    localparam int DATA_W              = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH = 2'd0,
        MODE_POP  = 2'd1,
        MODE_SWAP = 2'd2,
        MODE_EMIT = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_SHORT = 2'd3
    } t_status;

    // what a cell loads on the next clock
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ABOVE,
        CELL_BELOW,
        CELL_TOP
    } t_cell_op;

endpackage

// File: rtl/lse_in_if.sv
// lse_in_if: request channel of the stack engine (operation and value).
// Depends on lse_pkg for field widths.
interface lse_in_if;
    logic                              valid;
    logic                              ready;
    logic [lse_pkg::MODE_W-1:0]        mode;
    logic signed [lse_pkg::DATA_W-1:0] push_value;

    modport source (output valid, output mode, output push_value, input ready);
    modport sink   (input valid, input mode, input push_value, output ready);
endinterface

// File: rtl/lse_out_if.sv
// lse_out_if: result channel of the stack engine (value, status, last flag).
// Depends on lse_pkg for field widths.
interface lse_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [lse_pkg::DATA_W-1:0] out_value;
    logic [lse_pkg::STATUS_W-1:0]      status;
    logic                              is_last;

    modport source (output valid, output out_value, output status, output is_last,
                    input ready);
    modport sink   (input valid, input out_value, input status, input is_last,
                    output ready);
endinterface

// File: rtl/lse_cell.sv
// lse_cell: one stack slot; loads from its upper or lower neighbor or the top.
// Depends on lse_pkg (t_cell_op, defaults).
module lse_cell #(
    parameter int VALUE_WIDTH = lse_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  lse_pkg::t_cell_op      i_op,
    input  logic [VALUE_WIDTH-1:0] i_above,
    input  logic [VALUE_WIDTH-1:0] i_below,
    input  logic [VALUE_WIDTH-1:0] i_top,
    output logic [VALUE_WIDTH-1:0] o_value
);

    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;

    always_comb begin
        case (i_op)
            lse_pkg::CELL_ABOVE: n_value = i_above;
            lse_pkg::CELL_BELOW: n_value = i_below;
            lse_pkg::CELL_TOP:   n_value = i_top;
            default:             n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// File: rtl/lifo_stack_engine.sv
// lifo_stack_engine: bounded LIFO stack built as a chain of lse_cell slots.
// Depends on lse_pkg, lse_in_if, lse_out_if and lse_cell.
//
//   channel  dir  fields                          accepted when
//   i_req    in   mode, push_value                valid && ready
//   o_res    out  out_value, status, is_last      valid && ready
//
// Push, pop and swap: one request per cycle while no emit walk or held result stalls it, one status result each.
// Emit-all with n entries: the chain rotates its top n cells one place per cycle, unless a
// held result stalls it, and the top cell is shown, so the stack is whole again at the end.
// Emit on an empty stack: no result.
// Reset (synchronous): stack empty at once, no clearing pass; slot contents stay unknown.
// A result held in the output register stalls both new requests and the emit walk.
module lifo_stack_engine #(
    parameter int STACK_DEPTH = lse_pkg::DEFAULT_STACK_DEPTH,
    parameter int VALUE_WIDTH = lse_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lse_in_if.sink    i_req,
    lse_out_if.source o_res
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    logic [CNT_W-1:0]           r_count;
    logic                       r_emit;
    logic [IDX_W-1:0]           r_k;
    logic                       r_out_valid;
    logic [lse_pkg::DATA_W-1:0] r_out_value;
    lse_pkg::t_status           r_out_status;
    logic                       r_out_last;

    logic                       w_slot;
    logic                       w_acc;
    logic                       w_step;
    logic                       w_full;
    logic                       w_empty;
    logic                       w_short;
    logic                       w_walk_last;
    logic [CNT_W-1:0]           w_cnt_m1;
    lse_pkg::t_mode             w_mode;
    lse_pkg::t_status           w_status;
    logic signed [63:0]         w_push_ext;
    logic signed [63:0]         w_top_ext;
    logic [VALUE_WIDTH-1:0]     w_push_val;

    logic [VALUE_WIDTH-1:0]     w_cell [STACK_DEPTH];
    lse_pkg::t_cell_op          w_op   [STACK_DEPTH];

    assign w_mode      = lse_pkg::t_mode'(i_req.mode);
    assign w_slot      = !r_out_valid || o_res.ready;
    assign i_req.ready = !r_emit && w_slot;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_step      = r_emit && w_slot;
    assign w_full      = (r_count == CNT_W'(STACK_DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_short     = (r_count < CNT_W'(2));
    assign w_cnt_m1    = r_count - CNT_W'(1);
    assign w_walk_last = (r_k == w_cnt_m1[IDX_W-1:0]);

    assign w_push_ext  = 64'(i_req.push_value);
    assign w_push_val  = w_push_ext[VALUE_WIDTH-1:0];
    assign w_top_ext   = 64'(signed'(w_cell[0]));

    always_comb begin
        case (w_mode)
            lse_pkg::MODE_PUSH: w_status = w_full  ? lse_pkg::ST_FULL  : lse_pkg::ST_OK;
            lse_pkg::MODE_POP:  w_status = w_empty ? lse_pkg::ST_EMPTY : lse_pkg::ST_OK;
            lse_pkg::MODE_SWAP: w_status = w_short ? lse_pkg::ST_SHORT : lse_pkg::ST_OK;
            default:            w_status = lse_pkg::ST_OK;
        endcase
    end

    // per-cell load select
    always_comb begin
        for (int i = 0; i < STACK_DEPTH; i++) begin
            w_op[i] = lse_pkg::CELL_HOLD;
        end
        if (w_acc) begin
            case (w_mode)
                lse_pkg::MODE_PUSH: begin
                    if (!w_full) begin
                        for (int i = 0; i < STACK_DEPTH; i++) w_op[i] = lse_pkg::CELL_ABOVE;
                    end
                end
                lse_pkg::MODE_POP: begin
                    if (!w_empty) begin
                        for (int i = 0; i < STACK_DEPTH; i++) w_op[i] = lse_pkg::CELL_BELOW;
                    end
                end
                lse_pkg::MODE_SWAP: begin
                    if (!w_short) begin
                        w_op[0] = lse_pkg::CELL_BELOW;
                        w_op[1] = lse_pkg::CELL_ABOVE;
                    end
                end
                default: ;
            endcase
        end
        if (w_step) begin
            // rotate the occupied cells up; the top wraps into the deepest one
            for (int i = 0; i < STACK_DEPTH; i++) begin
                if (CNT_W'(i) < w_cnt_m1) begin
                    w_op[i] = lse_pkg::CELL_BELOW;
                end else if (CNT_W'(i) == w_cnt_m1) begin
                    w_op[i] = lse_pkg::CELL_TOP;
                end
            end
        end
    end

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_above;
        logic [VALUE_WIDTH-1:0] w_below;

        if (g == 0) begin : g_head
            assign w_above = w_push_val;
        end else begin : g_mid
            assign w_above = w_cell[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_tail
            assign w_below = w_cell[g];
        end else begin : g_link
            assign w_below = w_cell[g+1];
        end

        lse_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op[g]),
            .i_above (w_above),
            .i_below (w_below),
            .i_top   (w_cell[0]),
            .o_value (w_cell[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_emit      <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((w_acc && w_mode != lse_pkg::MODE_EMIT) || w_step) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_acc) begin
                case (w_mode)
                    lse_pkg::MODE_PUSH: begin
                        if (!w_full) r_count <= r_count + CNT_W'(1);
                    end
                    lse_pkg::MODE_POP: begin
                        if (!w_empty) r_count <= w_cnt_m1;
                    end
                    lse_pkg::MODE_SWAP: ;
                    default: begin
                        if (!w_empty) begin
                            r_emit <= 1'b1;
                            r_k    <= '0;
                        end
                    end
                endcase
            end
            if (w_step) begin
                r_k <= r_k + IDX_W'(1);
                if (w_walk_last) r_emit <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_mode != lse_pkg::MODE_EMIT) begin
            r_out_value  <= '0;
            r_out_status <= w_status;
            r_out_last   <= 1'b1;
        end else if (w_step) begin
            r_out_value  <= w_top_ext[lse_pkg::DATA_W-1:0];
            r_out_status <= lse_pkg::ST_OK;
            r_out_last   <= w_walk_last;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.out_value = r_out_value;
    assign o_res.status    = r_out_status;
    assign o_res.is_last   = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("fill count above stack depth");

    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit |-> (!w_empty && r_k <= w_cnt_m1[IDX_W-1:0]))
        else $error("emit walk past the occupied cells");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != lse_pkg::ST_OK) |-> r_out_last)
        else $error("error status without last flag");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_mode == lse_pkg::MODE_POP && !w_empty)
            |=> (r_count == $past(w_cnt_m1)))
        else $error("pop did not shrink the stack");

    a_walk_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_walk_last) |=> (!r_emit && r_out_valid && r_out_last))
        else $error("emit walk did not end on a last result");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for lifo_stack_engine: directed request table, then random mix.
// Depends on lse_pkg, lse_in_if, lse_out_if and the engine RTL; results are checked against a mirror stack.
module tb_top;

    localparam int DEPTH       = lse_pkg::DEFAULT_STACK_DEPTH;
    localparam int DW          = lse_pkg::DATA_W;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 27;

    typedef struct {
        logic signed [DW-1:0] value;
        lse_pkg::t_status     st;
        logic                 last;
    } t_stack_res;

    typedef struct {
        lse_pkg::t_mode       mode;
        logic signed [DW-1:0] value;
        bit                   typed;   // status result given right here
        lse_pkg::t_status     st;
    } t_req_row;

    logic i_clk;
    logic i_rst_n;

    lse_in_if  req_if ();
    lse_out_if res_if ();

    lifo_stack_engine u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    logic signed [DW-1:0] stack_mirror [DEPTH];
    int                   mirror_depth = 0;
    t_stack_res           pending_results [$];
    int                   mismatch_cnt = 0;
    int                   cycle_cnt    = 0;
    bit                   quiet        = 1'b0;   // no idling on either side

    // pop on empty, swap short, emit on empty, extremes, every operation
    t_req_row dir_tab [24] = '{
        '{lse_pkg::MODE_POP,  32'h0000_0000, 1'b1, lse_pkg::ST_EMPTY},
        '{lse_pkg::MODE_SWAP, 32'h0000_0000, 1'b1, lse_pkg::ST_SHORT},
        '{lse_pkg::MODE_EMIT, 32'h0000_0000, 1'b0, lse_pkg::ST_OK},
        '{lse_pkg::MODE_PUSH, 32'h8000_0000, 1'b1, lse_pkg::ST_OK},
        '{lse_pkg::MODE_SWAP, 32'hFFFF_FFFF, 1'b1, lse_pkg::ST_SHORT},
        '{lse_pkg::MODE_EMIT, 32'h0000_0000, 1'b0, lse_pkg::ST_OK},
        '{lse_pkg::MODE_PUSH, 32'h7FFF_FFFF, 1'b1, lse_pkg::ST_OK},
        '{lse_pkg::MODE_SWAP, 32'h0000_0000, 1'b1, lse_pkg::ST_OK},
        '{lse_pkg::MODE_EMIT, 32'h0000_0000, 1'b0, lse_pkg::ST_OK},
        '{lse_pkg::MODE_PUSH, 32'h0000_0000, 1'b1, lse_pkg::ST_OK},
        '{lse_pkg::MODE_PUSH, 32'hFFFF_FFFF, 1'b1, lse_pkg::ST_OK},
        '{lse_pkg::MODE_PUSH, 32'h0000_0001, 1'b1, lse_pkg::ST_OK},
        '{lse_pkg::MODE_SWAP, 32'h1234_5678, 1'b0, lse_pkg::ST_OK},
        '{lse_pkg::MODE_EMIT, 32'hFFFF_FFFF, 1'b0, lse_pkg::ST_OK},
        '{lse_pkg::MODE_POP,  32'h0000_0000, 1'b1, lse_pkg::ST_OK},
        '{lse_pkg::MODE_POP,  32'h0000_0000, 1'b0, lse_pkg::ST_OK},
        '{lse_pkg::MODE_POP,  32'h0000_0000, 1'b0, lse_pkg::ST_OK},
        '{lse_pkg::MODE_POP,  32'h0000_0000, 1'b0, lse_pkg::ST_OK},
        '{lse_pkg::MODE_POP,  32'h0000_0000, 1'b1, lse_pkg::ST_OK},
        '{lse_pkg::MODE_POP,  32'h0000_0000, 1'b1, lse_pkg::ST_EMPTY},
        '{lse_pkg::MODE_EMIT, 32'h0000_0000, 1'b0, lse_pkg::ST_OK},
        '{lse_pkg::MODE_PUSH, 32'h5555_5555, 1'b1, lse_pkg::ST_OK},
        '{lse_pkg::MODE_PUSH, 32'hAAAA_AAAA, 1'b1, lse_pkg::ST_OK},
        '{lse_pkg::MODE_EMIT, 32'h0000_0000, 1'b0, lse_pkg::ST_OK}
    };

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // mirror of the stack: queue up the results one request causes
    function automatic void apply_request(input lse_pkg::t_mode m,
                                          input logic signed [DW-1:0] v);
        logic signed [DW-1:0] t;
        case (m)
            lse_pkg::MODE_PUSH: begin
                if (mirror_depth >= DEPTH) begin
                    pending_results.push_back('{'0, lse_pkg::ST_FULL, 1'b1});
                end else begin
                    stack_mirror[mirror_depth] = v;
                    mirror_depth++;
                    pending_results.push_back('{'0, lse_pkg::ST_OK, 1'b1});
                end
            end
            lse_pkg::MODE_POP: begin
                if (mirror_depth == 0) begin
                    pending_results.push_back('{'0, lse_pkg::ST_EMPTY, 1'b1});
                end else begin
                    mirror_depth--;
                    pending_results.push_back('{'0, lse_pkg::ST_OK, 1'b1});
                end
            end
            lse_pkg::MODE_SWAP: begin
                if (mirror_depth < 2) begin
                    pending_results.push_back('{'0, lse_pkg::ST_SHORT, 1'b1});
                end else begin
                    t = stack_mirror[mirror_depth-1];
                    stack_mirror[mirror_depth-1] = stack_mirror[mirror_depth-2];
                    stack_mirror[mirror_depth-2] = t;
                    pending_results.push_back('{'0, lse_pkg::ST_OK, 1'b1});
                end
            end
            default: begin
                for (int k = 0; k < mirror_depth; k++)
                    pending_results.push_back('{stack_mirror[mirror_depth-1-k], lse_pkg::ST_OK,
                                                 (k == mirror_depth - 1)});
            end
        endcase
    endfunction

    task automatic send_request(input lse_pkg::t_mode m, input logic signed [DW-1:0] v);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.mode       <= m;
        req_if.push_value <= v;
        do @(posedge i_clk); while (!req_if.ready);
        apply_request(m, v);
    endtask

    // drop valid and hold off until every expected result is back
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic logic signed [DW-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // random requests with a per-phase operation mix; emit takes what is left
    task automatic run_phase(input int n, input int push_w, input int pop_w, input int swap_w,
                             input int quiet_n);
        int             r;
        lse_pkg::t_mode m;
        for (int i = 0; i < n; i++) begin
            quiet = (i < quiet_n);
            r = $urandom_range(99);
            if (r < push_w)                       m = lse_pkg::MODE_PUSH;
            else if (r < push_w + pop_w)          m = lse_pkg::MODE_POP;
            else if (r < push_w + pop_w + swap_w) m = lse_pkg::MODE_SWAP;
            else                                  m = lse_pkg::MODE_EMIT;
            send_request(m, pick_value());
        end
        quiet = 1'b0;
    endtask

    // result side: check, then pick ready for the next cycle
    always @(posedge i_clk) begin
        t_stack_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result: value=%0d status=%0d last=%0b",
                             res_if.out_value, res_if.status, res_if.is_last);
            end else begin
                want = pending_results.pop_front();
                if (res_if.out_value !== want.value || res_if.status !== want.st ||
                        res_if.is_last !== want.last) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"mismatch: value exp %0d got %0d, status exp %0d got %0d,",
                                  " last exp %0b got %0b"},
                                 want.value, res_if.out_value, want.st, res_if.status,
                                 want.last, res_if.is_last);
                end
            end
        end
        res_if.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    initial begin
        i_rst_n           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.mode       <= lse_pkg::MODE_PUSH;
        req_if.push_value <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            send_request(dir_tab[i].mode, dir_tab[i].value);
            if (dir_tab[i].typed)
                pending_results[pending_results.size()-1] = '{'0, dir_tab[i].st, 1'b1};
        end

        // sender holds off until every result is back
        wait_drained();
        run_phase(100, 85, 5, 5, 0);    // fill past full
        wait_drained();
        run_phase(100, 10, 75, 10, 0);  // drain past empty
        wait_drained();
        run_phase(100, 40, 30, 15, 50);

        wait_drained();
        repeat (DEPTH + 8) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/lse_pkg.sv
rtl/lse_in_if.sv
rtl/lse_out_if.sv
rtl/lse_cell.sv
rtl/lifo_stack_engine.sv
tb/sv/tb_top.sv
